[hw/rtl/u2a_pkg.sv]
`timescale 1ns / 1ps

package u2a_pkg;

	localparam int BinBits   = 64;
	localparam int DecDigits = 20;
	localparam int HexDigits = BinBits / 4;
	localparam int BcdBits   = DecDigits * 4;
	localparam int CharBits  = 7;
	localparam int BitCntW   = $clog2(BinBits);
	localparam int RemCntW   = $clog2(DecDigits + 1);

	localparam logic [CharBits-1:0] CharZero = 7'h30;
	localparam logic [CharBits-1:0] CharX    = 7'h78;
	localparam logic [CharBits-1:0] CharA    = 7'h41;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_PFX0,
		ST_PFX1,
		ST_EMIT
	} u2a_state_t;

	typedef enum logic [1:0] {
		EK_ZERO,
		EK_X,
		EK_DIGIT
	} u2a_emit_kind_t;

	typedef struct packed {
		logic           load;
		logic           step;
		logic           shift;
		logic           emit;
		u2a_emit_kind_t kind;
		logic           last;
	} u2a_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic top_zero;
		logic rem_one;
		logic out_free;
	} u2a_status_t;

	// Digit value to ASCII; BCD digits never exceed nine, hex nibbles may.
	function automatic logic [CharBits-1:0] digit_char(input logic [3:0] d);
		logic [CharBits-1:0] c;
		if (d < 4'd10) begin
			c = CharZero + {3'b000, d};
		end else begin
			c = CharA + {3'b000, d - 4'd10};
		end
		return c;
	endfunction

endpackage

[hw/rtl/u2a_in_if.sv]
`timescale 1ns / 1ps

interface u2a_in_if;
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [u2a_pkg::BinBits-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

[hw/rtl/u2a_out_if.sv]
`timescale 1ns / 1ps

interface u2a_out_if;
	logic                         valid;
	logic                         ready;
	logic [u2a_pkg::CharBits-1:0] character;
	logic                         last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

[hw/rtl/u64_to_ascii_number_formatter_unit.sv]
`timescale 1ns / 1ps

// Formats one unsigned 64-bit number per request as ASCII text, one character per
// output request, with last set on the final character. With op low the text is
// decimal, most significant digit first, without leading zeros ("0" for zero); with
// op high it is "0x" and sixteen upper-case hex digits. A decimal request is loaded,
// converted by shift-and-add-three in the BCD register and stripped of its leading
// zeros, then sends its digits one at a time as the output register frees up. A
// hex request is loaded and then sends its eighteen characters the same way.
// Requests are taken one at a time; the next one is accepted as soon as the last
// character of the current one sits in the output register, even if that
// character has not been taken yet. Nothing carries over from one request to the
// next.

module u64_to_ascii_number_formatter_unit (
	input  logic      clk,
	input  logic      arst_n,
	u2a_in_if.sink    number,
	u2a_out_if.source text
);
	import u2a_pkg::*;

	u2a_cmd_t    cmd;
	u2a_status_t status;

	// The controller sequences load, conversion, zero skipping and emission.
	u2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_op    (number.op),
		.in_ready (number.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the digit register, counters and the output register.
	u2a_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_op    (number.op),
		.in_value (number.value),
		.cmd      (cmd),
		.status   (status),
		.text     (text)
	);

endmodule

[hw/rtl/u2a_ctrl.sv]
`timescale 1ns / 1ps

module u2a_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_op,
	output logic                 in_ready,
	input  u2a_pkg::u2a_status_t status,
	output u2a_pkg::u2a_cmd_t    cmd
);
	import u2a_pkg::*;

	u2a_state_t state_q;
	u2a_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_op ? ST_PFX0 : ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.conv_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!status.top_zero || status.rem_one) begin
					state_d = ST_EMIT;
				end
			end
			ST_PFX0: begin
				if (status.out_free) begin
					state_d = ST_PFX1;
				end
			end
			ST_PFX1: begin
				if (status.out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.rem_one) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '{load: 1'b0, step: 1'b0, shift: 1'b0, emit: 1'b0,
			kind: EK_DIGIT, last: 1'b0};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_SKIP: begin
				// Leading zero digits are dropped, but the final digit always goes out.
				cmd.shift = status.top_zero && !status.rem_one;
			end
			ST_PFX0: begin
				cmd.emit = status.out_free;
				cmd.kind = EK_ZERO;
			end
			ST_PFX1: begin
				cmd.emit = status.out_free;
				cmd.kind = EK_X;
			end
			ST_EMIT: begin
				cmd.emit  = status.out_free;
				cmd.shift = status.out_free;
				cmd.kind  = EK_DIGIT;
				cmd.last  = status.rem_one;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/u2a_dpath.sv]
`timescale 1ns / 1ps

module u2a_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_op,
	input  logic [u2a_pkg::BinBits-1:0]  in_value,
	input  u2a_pkg::u2a_cmd_t            cmd,
	output u2a_pkg::u2a_status_t         status,
	u2a_out_if.source                    text
);
	import u2a_pkg::*;

	logic [BcdBits-1:0]  bcd_q;
	logic [BinBits-1:0]  bin_q;
	logic [BitCntW-1:0]  bit_cnt_q;
	logic [RemCntW-1:0]  rem_q;
	logic                out_valid_q;
	logic [CharBits-1:0] out_char_q;
	logic                out_last_q;
	logic [BcdBits-1:0]  bcd_adj;
	logic [3:0]          top_digit;
	logic [CharBits-1:0] emit_char;

	// Double-dabble correction: every digit of five or more gets three added.
	always_comb begin
		for (int i = 0; i < DecDigits; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BcdBits-1 -: 4];

	always_comb begin
		case (cmd.kind)
			EK_ZERO:  emit_char = CharZero;
			EK_X:     emit_char = CharX;
			EK_DIGIT: emit_char = digit_char(top_digit);
			default:  emit_char = CharZero;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= in_value;
			// Hex mode reuses the digit register: the value sits nibble-aligned at the top.
			bcd_q <= in_op ? {in_value, {(BcdBits-BinBits){1'b0}}} : '0;
		end else if (cmd.step) begin
			bcd_q <= {bcd_adj[BcdBits-2:0], bin_q[BinBits-1]};
			bin_q <= {bin_q[BinBits-2:0], 1'b0};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BcdBits-5:0], 4'h0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			rem_q     <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= '0;
			rem_q     <= in_op ? RemCntW'(HexDigits) : RemCntW'(DecDigits);
		end else begin
			if (cmd.step) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			if (cmd.shift) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= emit_char;
			out_last_q <= cmd.last;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

	assign status.conv_done = (bit_cnt_q == BitCntW'(BinBits - 1));
	assign status.top_zero  = (top_digit == 4'h0);
	assign status.rem_one   = (rem_q == RemCntW'(1));
	assign status.out_free  = !out_valid_q || text.ready;

endmodule

[tb/sv/u64_to_ascii_number_formatter_unit_tb.sv]
`timescale 1ns / 1ps

// Testbench for the 64-bit number to ASCII text formatter.
//
// Each request carries a format mode and a 64-bit value. The unit answers with a
// stream of characters, one per output handshake, with last set on the final one.
// The bench keeps a queue of the characters it expects. A request is either checked
// against text typed straight into the stimulus table, for rows whose text is obvious,
// or against a predictor that forms the decimal or hex text in plain SystemVerilog.
// Every character taken from the unit is compared with the oldest expected one.
module u64_to_ascii_number_formatter_unit_tb;
	import u2a_pkg::*;

	// Format modes carried in the op field of a request.
	localparam logic FMT_DEC = 1'b0;
	localparam logic FMT_HEX = 1'b1;

	localparam int RandomRequests = 91;
	localparam int SteadyTail     = 20;    // last random requests run without idling
	localparam int LongHoldAt     = 40;    // requests taken before the long output hold
	localparam int LongHold       = 400;   // cycles the output side holds off
	localparam int DrainCycles    = 100;   // one decimal conversion plus margin
	localparam int QuietLimit     = 3000;  // cycles with no handshake before giving up

	typedef struct packed {
		logic [CharBits-1:0] code;
		logic                last;
	} text_char_t;

	typedef struct {
		logic               fmt;
		logic [BinBits-1:0] value;
		string              typed;   // expected text, empty when the predictor decides
	} number_row_t;

	logic clk;
	logic arst_n;

	u2a_in_if  number_if ();
	u2a_out_if text_if ();

	u64_to_ascii_number_formatter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_if),
		.text   (text_if)
	);

	text_char_t text_expected[$];
	int         requests_taken;
	int         mismatches;
	bit         steady_tail;

	// Directed requests: the zero value in both modes, both ends of the range, the
	// points where the decimal digit count changes, and hex values that use every
	// nibble value in both the upper and lower positions.
	number_row_t directed_rows [19] = '{
		'{FMT_DEC, 64'd0,                     "0"},
		'{FMT_HEX, 64'd0,                     "0x0000000000000000"},
		'{FMT_DEC, 64'hFFFF_FFFF_FFFF_FFFF,   "18446744073709551615"},
		'{FMT_HEX, 64'hFFFF_FFFF_FFFF_FFFF,   "0xFFFFFFFFFFFFFFFF"},
		'{FMT_DEC, 64'd1,                     "1"},
		'{FMT_HEX, 64'd1,                     "0x0000000000000001"},
		'{FMT_DEC, 64'd9,                     ""},
		'{FMT_DEC, 64'd10,                    ""},
		'{FMT_DEC, 64'd99,                    ""},
		'{FMT_DEC, 64'd100,                   ""},
		'{FMT_DEC, 64'd9999999999999999999,   ""},
		'{FMT_DEC, 64'd10000000000000000000,  ""},
		'{FMT_DEC, 64'h8000_0000_0000_0000,   ""},
		'{FMT_DEC, 64'h7FFF_FFFF_FFFF_FFFF,   ""},
		'{FMT_DEC, 64'd12345678901234567890,  ""},
		'{FMT_HEX, 64'h0123_4567_89AB_CDEF,   ""},
		'{FMT_HEX, 64'hFEDC_BA98_7654_3210,   ""},
		'{FMT_HEX, 64'h8000_0000_0000_0000,   ""},
		'{FMT_HEX, 64'hA5A5_5A5A_C3C3_3C3C,   ""}
	};

	always #4 clk = ~clk;

	// Works out the characters a request should produce and queues them.
	function automatic void predict_text(input logic fmt, input logic [BinBits-1:0] value);
		logic [3:0]         digits [DecDigits];
		logic [BinBits-1:0] rest;
		logic [3:0]         nib;
		int                 count;
		rest  = value;
		count = 0;
		if (fmt == FMT_DEC) begin
			if (value == '0) begin
				text_expected.push_back('{CharZero, 1'b1});
			end else begin
				while (rest != '0) begin
					digits[count] = 4'(rest % 10);
					rest          = rest / 10;
					count++;
				end
				for (int i = count - 1; i >= 0; i--) begin
					text_expected.push_back('{CharZero + {3'b000, digits[i]}, i == 0});
				end
			end
		end else begin
			text_expected.push_back('{CharZero, 1'b0});
			text_expected.push_back('{CharX, 1'b0});
			for (int i = HexDigits - 1; i >= 0; i--) begin
				nib = value[i*4 +: 4];
				if (nib < 4'd10) begin
					text_expected.push_back('{CharZero + {3'b000, nib}, i == 0});
				end else begin
					text_expected.push_back('{CharA + {3'b000, nib - 4'd10}, i == 0});
				end
			end
		end
	endfunction

	// Sender idling: random gaps between requests, none in calm stretches or the tail.
	function automatic int draw_gap(input bit calm);
		if (calm || steady_tail || $urandom_range(0, 2) != 0) begin
			return 0;
		end
		return $urandom_range(1, 16);
	endfunction

	// Random values shaped so that every decimal length and the digit count
	// boundaries come up often, not only the 19 and 20 digit numbers that a flat
	// 64-bit draw would give almost every time.
	function automatic logic [BinBits-1:0] draw_value();
		logic [BinBits-1:0] v;
		logic [BinBits-1:0] power;
		int                 exponent;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: begin
				v = v >> $urandom_range(0, BinBits - 1);
			end
			1: begin
				power    = 64'd1;
				exponent = $urandom_range(0, DecDigits - 1);
				for (int i = 0; i < exponent; i++) begin
					power = power * 10;
				end
				v = power + 64'($urandom_range(0, 2)) - 64'd1;
			end
			2: begin
				v = 64'($urandom_range(0, 1000));
			end
			3: begin
				v = ~64'($urandom_range(0, 50));
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// Offers one request, waits for it to be taken, then queues its text. The
	// task starts and ends on a falling edge, so valid gets at most one update
	// per edge and stays high between back-to-back requests.
	task automatic offer_request(input logic fmt, input logic [BinBits-1:0] value,
			input string typed, input int gap);
		if (gap > 0) begin
			number_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		number_if.valid <= 1'b1;
		number_if.op    <= fmt;
		number_if.value <= value;
		do begin
			@(posedge clk);
		end while (!number_if.ready);
		requests_taken++;
		if (typed.len() != 0) begin
			for (int i = 0; i < typed.len(); i++) begin
				text_expected.push_back('{CharBits'(typed[i]), i == typed.len() - 1});
			end
		end else begin
			predict_text(fmt, value);
		end
		@(negedge clk);
	endtask

	// Request side: reset, the directed table, then the random requests. Calm
	// stretches without gaps are chosen every eight requests so that long
	// back-to-back runs appear next to the bursty ones.
	initial begin : request_side
		bit calm;
		clk             = 1'b0;
		arst_n          = 1'b0;
		number_if.valid = 1'b0;
		number_if.op    = FMT_DEC;
		number_if.value = '0;
		requests_taken  = 0;
		mismatches      = 0;
		steady_tail     = 1'b0;
		calm            = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			offer_request(directed_rows[i].fmt, directed_rows[i].value,
				directed_rows[i].typed, draw_gap(calm));
		end

		for (int i = 0; i < RandomRequests; i++) begin
			if (i % 8 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			if (i == RandomRequests - SteadyTail) begin
				steady_tail = 1'b1;
			end
			offer_request(logic'($urandom_range(0, 1)), draw_value(), "", draw_gap(calm));
		end
		number_if.valid <= 1'b0;

		// Drain: every expected character must arrive, then nothing more may follow.
		while (text_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("[u64_to_ascii_number_formatter_unit] OK");
		end else begin
			$display("[u64_to_ascii_number_formatter_unit] ERROR");
		end
		$finish;
	end

	// Output side: random stalls with calm stretches in between,
	// and one long hold once enough requests have gone in. During that hold the
	// unit parks a character in its output register and must stop taking requests
	// while the request side keeps offering.
	initial begin : text_side
		int  stall_left;
		int  calm_left;
		bit  long_hold_done;
		text_if.ready  = 1'b0;
		stall_left     = 0;
		calm_left      = 0;
		long_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && requests_taken >= LongHoldAt) begin
				long_hold_done = 1'b1;
				stall_left     = LongHold;
			end
			if (steady_tail) begin
				text_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				text_if.ready <= 1'b0;
				stall_left--;
			end else begin
				text_if.ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else if ($urandom_range(0, 40) == 0) begin
					calm_left = $urandom_range(30, 120);
				end else if ($urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 16);
				end
			end
		end
	end

	// Character checker: each character taken is compared field by field with the
	// oldest expectation. Case inequality makes an unknown output count as wrong.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && text_if.valid && text_if.ready) begin
			if (text_expected.size() == 0) begin
				$display("%0t: unexpected character %h last %b", $time,
					text_if.character, text_if.last);
				mismatches++;
			end else begin
				want = text_expected.pop_front();
				if (text_if.character !== want.code) begin
					$display("%0t: character expected %h got %h", $time,
						want.code, text_if.character);
					mismatches++;
				end
				if (text_if.last !== want.last) begin
					$display("%0t: last expected %b got %b", $time,
						want.last, text_if.last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: the longest correct quiet stretch is the long output hold, or a
	// decimal conversion behind a stall, so a much longer one means a hang.
	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n ||
				(number_if.valid && number_if.ready) || (text_if.valid && text_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("[u64_to_ascii_number_formatter_unit] ERROR");
				$finish;
			end
		end
	end

endmodule
